FILE: src/packbits_row_decoder_defines.svh
// Assertion macros shared by the PackBits row decoder modules.
// Expects clk and arst_n to be in scope where a macro is used.
`ifndef PACKBITS_ROW_DECODER_DEFINES_SVH
`define PACKBITS_ROW_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/pbrd_pkg.sv
// Package for the PackBits row decoder: defaults, phase and status codes,
// register indexes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package pbrd_pkg;

	// Parameter defaults
	localparam int OUT_LANES_DEF     = 4;
	localparam int ROW_MAX_BYTES_DEF = 65535;

	// Decode phase codes
	localparam logic [1:0] PH_FLAG = 2'd0;
	localparam logic [1:0] PH_LIT  = 2'd1;
	localparam logic [1:0] PH_REP  = 2'd2;
	localparam logic [1:0] PH_DROP = 2'd3;

	// Row status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_MIDRUN = 2'd1;
	localparam logic [1:0] STAT_LIMIT  = 2'd2;

	// Configuration register indexes
	localparam logic REG_WORD_MODE = 1'b0;
	localparam logic REG_OUT_LIMIT = 1'b1;

	// Reset values of the configuration registers
	localparam logic [15:0] OUT_LIMIT_RST = 16'hFFFF;

	// Controller to datapath
	typedef struct packed {
		logic take_item;   // input beat accepted, update row state
		logic load_item;   // load the single result of the accepted item
		logic emit_group;  // load the next repeat group into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic item_res;    // current input yields exactly one immediate result
		logic item_run;    // current input starts a repeat burst
		logic run_last;    // pending repeat group is the final one
	} sts_t;

endpackage

FILE: src/pbrd_ctrl.sv
// Controller of the PackBits row decoder: input/output handshake and
// item/burst sequencing. Depends on pbrd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "packbits_row_decoder_defines.svh"

module pbrd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  pbrd_pkg::sts_t  sts,
	output pbrd_pkg::cmd_t  cmd
);

	localparam logic ST_ITEM = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic slot_free;
	logic in_fire;

	// Output slot frees when empty or when its beat is taken
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_ITEM) && slot_free;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Issue commands
	always_comb begin
		cmd.take_item  = in_fire;
		cmd.load_item  = in_fire && sts.item_res;
		cmd.emit_group = (state_q == ST_RUN) && slot_free;
	end

	// Sequence items and repeat bursts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ITEM;
		end else begin
			unique case (state_q)
				ST_ITEM: begin
					if (in_fire && sts.item_run) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.emit_group && sts.run_last) begin
						state_q <= ST_ITEM;
					end
				end
				default: begin
					state_q <= ST_ITEM;
				end
			endcase
		end
	end

	// Track output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= cmd.load_item || cmd.emit_group;
		end
	end

	`PBRD_ASSERT_NOW(a_no_input_in_burst, state_q == ST_RUN, !in_ready, "input taken during burst")
	`PBRD_ASSERT_NEXT(a_burst_starts, in_fire && sts.item_run, state_q == ST_RUN, "burst did not start")
	`PBRD_ASSERT_NEXT(a_burst_ends, cmd.emit_group && sts.run_last, state_q == ST_ITEM, "burst did not end")
	`PBRD_ASSERT_NOW(a_item_kind_excl, 1'b1, !(sts.item_res && sts.item_run), "item both single and burst")
	`PBRD_ASSERT_NEXT(a_load_shows, cmd.load_item || cmd.emit_group, out_valid_q, "loaded beat not shown")

endmodule

FILE: src/pbrd_datapath.sv
// Datapath of the PackBits row decoder: configuration registers, row decode
// state, repeat burst generator and output register. Depends on pbrd_pkg.
`timescale 1ns / 1ps

module pbrd_datapath #(
	parameter int OUT_LANES     = pbrd_pkg::OUT_LANES_DEF,
	parameter int ROW_MAX_BYTES = pbrd_pkg::ROW_MAX_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_fire,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic [7:0]      src_byte,
	input  logic            row_last,
	input  pbrd_pkg::cmd_t  cmd,
	output pbrd_pkg::sts_t  sts,
	output logic [7:0]      ob [4],
	output logic [2:0]      byte_count,
	output logic            run_end,
	output logic            row_end,
	output logic [1:0]      row_status,
	output logic [15:0]     produced
);

	localparam int LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);
	localparam logic [8:0]  LanesW   = 9'(LANES);
	localparam logic [2:0]  LanesC   = 3'(LANES);
	localparam logic        LanesOdd = 1'(LANES);
	localparam logic [15:0] RowMax   = 16'(ROW_MAX_BYTES);

	// Configuration
	logic        word_mode_q;
	logic [15:0] out_limit_q;

	// Row state
	logic [1:0]  phase_q, phase_n;
	logic [7:0]  run_left_q, run_left_n;
	logic [7:0]  first_half_q, first_half_n;
	logic        half_seen_q, half_n;
	logic [15:0] out_total_q;
	logic [1:0]  err_q, err_n;
	logic        limit_q, limit_n;

	// Repeat burst
	logic [8:0]  rep_left_q;
	logic [7:0]  rep_hi_q, rep_lo_q;
	logic        rep_par_q;
	logic        rep_last_q;
	logic [1:0]  rep_stat_q;
	logic [15:0] rep_prod_q;

	// Output register
	logic [7:0]  ob_q [4];
	logic [2:0]  cnt_q;
	logic        run_end_q, row_end_q;
	logic [1:0]  stat_q;
	logic [15:0] prod_q;

	logic [15:0] lim;
	logic [8:0]  units, need;
	logic [16:0] sum_need;
	logic        at_limit, overrun;
	logic [8:0]  nb_item;
	logic [1:0]  item_stat;
	logic [2:0]  grp_cnt;
	logic [7:0]  grp_b [4];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_mode_q <= 1'b0;
			out_limit_q <= pbrd_pkg::OUT_LIMIT_RST;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				pbrd_pkg::REG_WORD_MODE: word_mode_q <= cfg_data[0];
				pbrd_pkg::REG_OUT_LIMIT: out_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Size a run from its flag byte and check it against the limit
	always_comb begin
		lim      = (out_limit_q > RowMax) ? RowMax : out_limit_q;
		units    = src_byte[7] ? (9'd257 - {1'b0, src_byte}) : ({1'b0, src_byte} + 9'd1);
		need     = word_mode_q ? {units[7:0], 1'b0} : units;
		sum_need = {1'b0, out_total_q} + {8'd0, need};
		overrun  = sum_need > {1'b0, lim};
		at_limit = limit_q || (out_total_q >= lim);
	end

	// Advance the decode phase for one source byte
	always_comb begin
		phase_n      = phase_q;
		run_left_n   = run_left_q;
		first_half_n = first_half_q;
		half_n       = half_seen_q;
		err_n        = err_q;
		limit_n      = limit_q;
		nb_item      = 9'd0;
		unique case (phase_q)
			pbrd_pkg::PH_FLAG: begin
				if (at_limit) begin
					limit_n = 1'b1;
					phase_n = pbrd_pkg::PH_DROP;
				end else if (src_byte != 8'h80) begin
					if (overrun) begin
						err_n   = pbrd_pkg::STAT_LIMIT;
						phase_n = pbrd_pkg::PH_DROP;
					end else begin
						run_left_n = units[7:0];
						half_n     = 1'b0;
						phase_n    = src_byte[7] ? pbrd_pkg::PH_REP : pbrd_pkg::PH_LIT;
					end
				end
			end
			pbrd_pkg::PH_LIT: begin
				nb_item = 9'd1;
				if (word_mode_q && !half_seen_q) begin
					half_n = 1'b1;
				end else begin
					half_n = 1'b0;
					if (run_left_q != 8'd0) begin
						run_left_n = run_left_q - 8'd1;
					end
				end
				if (run_left_n == 8'd0) begin
					phase_n = pbrd_pkg::PH_FLAG;
				end
			end
			pbrd_pkg::PH_REP: begin
				if (word_mode_q && !half_seen_q) begin
					first_half_n = src_byte;
					half_n       = 1'b1;
				end else begin
					nb_item    = word_mode_q ? {run_left_q, 1'b0} : {1'b0, run_left_q};
					run_left_n = 8'd0;
					half_n     = 1'b0;
					phase_n    = pbrd_pkg::PH_FLAG;
				end
			end
			default: ;
		endcase
	end

	// Row status on the closing beat
	always_comb begin
		if (!row_last) begin
			item_stat = pbrd_pkg::STAT_OK;
		end else if (err_n != pbrd_pkg::STAT_OK) begin
			item_stat = err_n;
		end else if ((phase_n == pbrd_pkg::PH_LIT) || (phase_n == pbrd_pkg::PH_REP)) begin
			item_stat = pbrd_pkg::STAT_MIDRUN;
		end else begin
			item_stat = pbrd_pkg::STAT_OK;
		end
	end

	// Report item kind and burst progress
	always_comb begin
		sts.item_res = (phase_q == pbrd_pkg::PH_LIT) || ((nb_item == 9'd0) && row_last);
		sts.item_run = (phase_q == pbrd_pkg::PH_REP) && !(word_mode_q && !half_seen_q);
		sts.run_last = rep_left_q <= LanesW;
	end

	// Update row state; clear it at the row's last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= pbrd_pkg::PH_FLAG;
			run_left_q   <= 8'd0;
			first_half_q <= 8'd0;
			half_seen_q  <= 1'b0;
			out_total_q  <= 16'd0;
			err_q        <= pbrd_pkg::STAT_OK;
			limit_q      <= 1'b0;
		end else if (cmd.take_item) begin
			if (row_last) begin
				phase_q      <= pbrd_pkg::PH_FLAG;
				run_left_q   <= 8'd0;
				first_half_q <= 8'd0;
				half_seen_q  <= 1'b0;
				out_total_q  <= 16'd0;
				err_q        <= pbrd_pkg::STAT_OK;
				limit_q      <= 1'b0;
			end else begin
				phase_q      <= phase_n;
				run_left_q   <= run_left_n;
				first_half_q <= first_half_n;
				half_seen_q  <= half_n;
				out_total_q  <= out_total_q + {7'd0, nb_item};
				err_q        <= err_n;
				limit_q      <= limit_n;
			end
		end
	end

	// Build the pending repeat group
	always_comb begin
		grp_cnt = (rep_left_q > LanesW) ? LanesC : rep_left_q[2:0];
		for (int j = 0; j < 4; j++) begin
			if (3'(j) < grp_cnt) begin
				grp_b[j] = (rep_par_q ^ 1'(j)) ? rep_lo_q : rep_hi_q;
			end else begin
				grp_b[j] = 8'd0;
			end
		end
	end

	// Load a burst at the item, then step it one group per beat
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			rep_left_q <= nb_item;
			rep_hi_q   <= word_mode_q ? first_half_q : src_byte;
			rep_lo_q   <= src_byte;
			rep_par_q  <= 1'b0;
			rep_last_q <= row_last;
			rep_stat_q <= item_stat;
			rep_prod_q <= out_total_q;
		end else if (cmd.emit_group) begin
			rep_left_q <= rep_left_q - {6'd0, grp_cnt};
			rep_par_q  <= rep_par_q ^ LanesOdd;
			rep_prod_q <= rep_prod_q + {13'd0, grp_cnt};
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			ob_q[0]   <= (phase_q == pbrd_pkg::PH_LIT) ? src_byte : 8'd0;
			ob_q[1]   <= 8'd0;
			ob_q[2]   <= 8'd0;
			ob_q[3]   <= 8'd0;
			cnt_q     <= nb_item[2:0];
			run_end_q <= 1'b1;
			row_end_q <= row_last;
			stat_q    <= item_stat;
			prod_q    <= out_total_q + {7'd0, nb_item};
		end else if (cmd.emit_group) begin
			ob_q      <= grp_b;
			cnt_q     <= grp_cnt;
			run_end_q <= sts.run_last;
			row_end_q <= sts.run_last && rep_last_q;
			stat_q    <= (sts.run_last && rep_last_q) ? rep_stat_q : pbrd_pkg::STAT_OK;
			prod_q    <= rep_prod_q + {13'd0, grp_cnt};
		end
	end

	assign ob         = ob_q;
	assign byte_count = cnt_q;
	assign run_end    = run_end_q;
	assign row_end    = row_end_q;
	assign row_status = stat_q;
	assign produced   = prod_q;

endmodule

FILE: src/packbits_row_decoder.sv
// PackBits row decoder: one compressed byte per input beat, decoded bytes out
// in groups of up to four per output beat. Flag, literal and dropped bytes are
// taken one per cycle while the output slot is free; a repeat's value byte is
// taken and then holds the input while its ceil(bytes / lanes) groups leave the
// single output register, one group a cycle unless the output stalls. Lanes are
// OUT_LANES clamped to 1..4. A run that would pass the limit (the smaller of
// out_limit and ROW_MAX_BYTES) sends nothing, drops the rest of the row and
// closes it with status 2; a row ending mid-run closes with status 1. Write
// configuration only between rows.
// Top level; depends on pbrd_pkg, pbrd_ctrl and pbrd_datapath.
`timescale 1ns / 1ps

module packbits_row_decoder #(
	parameter int OUT_LANES     = pbrd_pkg::OUT_LANES_DEF,
	parameter int ROW_MAX_BYTES = pbrd_pkg::ROW_MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  src_byte,
	input  logic        row_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_b0,
	output logic [7:0]  out_b1,
	output logic [7:0]  out_b2,
	output logic [7:0]  out_b3,
	output logic [2:0]  byte_count,
	output logic        run_end,
	output logic        row_end,
	output logic [1:0]  row_status,
	output logic [15:0] produced
);

	pbrd_pkg::cmd_t cmd;
	pbrd_pkg::sts_t sts;
	logic [7:0]     ob [4];

	// Configuration beats are always taken
	assign cfg_ready = 1'b1;

	pbrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pbrd_datapath #(
		.OUT_LANES     (OUT_LANES),
		.ROW_MAX_BYTES (ROW_MAX_BYTES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_fire   (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.src_byte   (src_byte),
		.row_last   (row_last),
		.cmd        (cmd),
		.sts        (sts),
		.ob         (ob),
		.byte_count (byte_count),
		.run_end    (run_end),
		.row_end    (row_end),
		.row_status (row_status),
		.produced   (produced)
	);

	assign out_b0 = ob[0];
	assign out_b1 = ob[1];
	assign out_b2 = ob[2];
	assign out_b3 = ob[3];

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for packbits_row_decoder: directed rows, then random phases.
// A scoreboard class predicts every output beat from the accepted input beats.
// Depends on pbrd_pkg and the packbits_row_decoder RTL.
`timescale 1ns / 1ps

typedef struct packed {
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [7:0]  b3;
	logic [2:0]  count;
	logic        run_end;
	logic        row_end;
	logic [1:0]  status;
	logic [15:0] produced;
} pbrd_group_t;

class packbits_groups_sb;
	bit          word_mode;
	bit [15:0]   out_limit;
	logic [1:0]  phase;
	bit [7:0]    run_left;
	bit [7:0]    first_half;
	bit          half_seen;
	bit [15:0]   out_total;
	logic [1:0]  err_code;
	bit          limit_reached;
	int          lanes;
	int          fails;
	pbrd_group_t pending_groups[$];

	function new();
		lanes = pbrd_pkg::OUT_LANES_DEF;
		if (lanes < 1) lanes = 1;
		if (lanes > 4) lanes = 4;
		word_mode = 1'b0;
		out_limit = pbrd_pkg::OUT_LIMIT_RST;
		fails = 0;
		clear_row();
	endfunction

	function void clear_row();
		phase = pbrd_pkg::PH_FLAG;
		run_left = '0;
		first_half = '0;
		half_seen = 1'b0;
		out_total = '0;
		err_code = pbrd_pkg::STAT_OK;
		limit_reached = 1'b0;
	endfunction

	function void write_reg(logic idx, logic [15:0] data);
		if (idx == pbrd_pkg::REG_WORD_MODE) word_mode = data[0];
		else out_limit = data;
	endfunction

	function string fmt_group(pbrd_group_t g);
		return $sformatf("bytes=%h %h %h %h cnt=%0d run_end=%b row_end=%b status=%0d %s%0d",
			g.b0, g.b1, g.b2, g.b3, g.count, g.run_end, g.row_end, g.status,
			"produced=", g.produced);
	endfunction

	// Decode one source byte and queue the groups it yields
	function void decode_byte(logic [7:0] v, logic last);
		bit [7:0]    bytes_q[$];
		int unsigned lim, base, units, nres, start, cnt, k;
		logic [1:0]  status;
		pbrd_group_t g;
		lim = 32'(out_limit);
		if (lim > pbrd_pkg::ROW_MAX_BYTES_DEF) lim = pbrd_pkg::ROW_MAX_BYTES_DEF;
		base = 32'(out_total);
		case (phase)
			pbrd_pkg::PH_FLAG: begin
				if (limit_reached || out_total >= lim) begin
					// limit hit exactly: ignore the rest of the row
					limit_reached = 1'b1;
					phase = pbrd_pkg::PH_DROP;
				end else if (v != 8'h80) begin
					units = (v < 8'h80) ? int'(v) + 1 : 257 - int'(v);
					if (base + (word_mode ? 2 * units : units) > lim) begin
						err_code = pbrd_pkg::STAT_LIMIT;
						phase = pbrd_pkg::PH_DROP;
					end else begin
						run_left = 8'(units);
						half_seen = 1'b0;
						phase = (v < 8'h80) ? pbrd_pkg::PH_LIT : pbrd_pkg::PH_REP;
					end
				end
			end
			pbrd_pkg::PH_LIT: begin
				bytes_q.push_back(v);
				if (word_mode && !half_seen) begin
					half_seen = 1'b1;
				end else begin
					half_seen = 1'b0;
					if (run_left > 0) run_left--;
				end
				if (run_left == 0) phase = pbrd_pkg::PH_FLAG;
			end
			pbrd_pkg::PH_REP: begin
				if (word_mode && !half_seen) begin
					first_half = v;
					half_seen = 1'b1;
				end else begin
					repeat (run_left) begin
						if (word_mode) bytes_q.push_back(first_half);
						bytes_q.push_back(v);
					end
					run_left = '0;
					half_seen = 1'b0;
					phase = pbrd_pkg::PH_FLAG;
				end
			end
			default: ;
		endcase

		out_total = 16'(base + bytes_q.size());
		status = pbrd_pkg::STAT_OK;
		if (last) begin
			if (err_code != pbrd_pkg::STAT_OK) status = err_code;
			else if (phase == pbrd_pkg::PH_LIT || phase == pbrd_pkg::PH_REP)
				status = pbrd_pkg::STAT_MIDRUN;
		end

		// split into lane-wide beats; a row end with no bytes still gets one beat
		nres = (bytes_q.size() + lanes - 1) / lanes;
		if (nres == 0 && last) nres = 1;
		for (k = 0; k < nres; k++) begin
			start = k * lanes;
			cnt = 0;
			if (start < bytes_q.size()) begin
				cnt = bytes_q.size() - start;
				if (cnt > lanes) cnt = lanes;
			end
			g = '0;
			if (cnt > 0) g.b0 = bytes_q[start];
			if (cnt > 1) g.b1 = bytes_q[start + 1];
			if (cnt > 2) g.b2 = bytes_q[start + 2];
			if (cnt > 3) g.b3 = bytes_q[start + 3];
			g.count = 3'(cnt);
			g.run_end = (k == nres - 1);
			g.row_end = last && (k == nres - 1);
			g.status = g.row_end ? status : pbrd_pkg::STAT_OK;
			g.produced = 16'(base + start + cnt);
			pending_groups.push_back(g);
		end

		if (last) clear_row();
	endfunction

	// Compare one output beat against the oldest predicted group
	function void check_group(pbrd_group_t got);
		pbrd_group_t want;
		if (pending_groups.size() == 0) begin
			fails++;
			if (fails <= 10) $display("ERROR: unexpected output beat: %s", fmt_group(got));
		end else begin
			want = pending_groups.pop_front();
			if (got !== want) begin
				fails++;
				if (fails <= 10) begin
					$display("ERROR: output beat mismatch");
					$display("  expected %s", fmt_group(want));
					$display("  actual   %s", fmt_group(got));
				end
			end
		end
	endfunction
endclass

module tb_top;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 120;
	localparam int RANDOM_PHASES = 6;
	localparam int ROWS_PER_PHASE_MAX = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = pbrd_pkg::REG_WORD_MODE;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  src_byte = '0;
	logic        row_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_b0;
	logic [7:0]  out_b1;
	logic [7:0]  out_b2;
	logic [7:0]  out_b3;
	logic [2:0]  byte_count;
	logic        run_end;
	logic        row_end;
	logic [1:0]  row_status;
	logic [15:0] produced;

	packbits_groups_sb sb;
	bit       idle_en = 1'b1;
	int       stall_left = 0;
	int       cycles = 0;
	int       sent_items = 0;
	bit [7:0] row_q[$];

	packbits_row_decoder DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Check output beats and stall the output in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_group({out_b0, out_b1, out_b2, out_b3, byte_count, run_end, row_end,
				row_status, produced});
		if (stall_left != 0) begin
			out_ready <= (stall_left == 1);
			stall_left = stall_left - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Drive one source byte, with an optional idle burst ahead of it
	task automatic send_item(input logic [7:0] b, input logic last);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		src_byte <= b;
		row_last <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.decode_byte(b, last);
		sent_items++;
	endtask

	task automatic send_row();
		for (int i = 0; i < row_q.size(); i++)
			send_item(row_q[i], i == row_q.size() - 1);
	endtask

	// Hold the input until every predicted beat has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_groups.size() != 0);
	endtask

	// Write both registers while the decoder is idle
	task automatic set_config(input logic wm, input logic [15:0] lim);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_index <= pbrd_pkg::REG_WORD_MODE;
		cfg_data <= {15'd0, wm};
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(pbrd_pkg::REG_WORD_MODE, {15'd0, wm});
		cfg_index <= pbrd_pkg::REG_OUT_LIMIT;
		cfg_data <= lim;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(pbrd_pkg::REG_OUT_LIMIT, lim);
		cfg_valid <= 1'b0;
	endtask

	// Build a random row: mostly well-formed runs, some cut short, some noise
	function automatic void build_row(bit wm);
		int kind;
		int sel;
		int units;
		int keep;
		row_q.delete();
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 6)) row_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(1, 4)) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				row_q.push_back(8'h80);
			end else if (sel <= 5) begin
				units = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128)
					: $urandom_range(1, 6);
				row_q.push_back(8'(units - 1));
				repeat (wm ? 2 * units : units) row_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				units = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 128)
					: $urandom_range(2, 8);
				row_q.push_back(8'(257 - units));
				repeat (wm ? 2 : 1) row_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		// cut the row short so it ends inside a run
		if (kind >= 7 && row_q.size() > 1) begin
			keep = $urandom_range(1, row_q.size() - 1);
			while (row_q.size() > keep) void'(row_q.pop_back());
		end
	endfunction

	initial begin
		int       rows;
		bit       wm;
		bit [15:0] lim;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Byte mode at reset settings: no-op flag, literal, longest repeat, short repeat
		row_q = '{8'h80, 8'h01, 8'hFF, 8'h00, 8'h81, 8'hA5, 8'hFF, 8'h5A};
		send_row();
		// row end with no output
		row_q = '{8'h80};
		send_row();
		// row ends inside a literal
		row_q = '{8'h03, 8'h11, 8'h22};
		send_row();
		// repeat whose value never arrives
		row_q = '{8'hFE};
		send_row();

		// Word mode with a tiny limit: exact hit, overrun, word repeat
		set_config(1'b1, 16'd4);
		row_q = '{8'h01, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00};
		send_row();
		row_q = '{8'h7F, 8'h00};
		send_row();
		row_q = '{8'hFF, 8'h12, 8'h34};
		send_row();

		// Random phases, each with its own settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					wm = 1'b0;
					lim = 16'hFFFF;
				end
				1: begin
					wm = 1'b1;
					lim = 16'd0;
				end
				2: begin
					wm = 1'($urandom_range(0, 1));
					lim = 16'($urandom_range(1, 64));
				end
				3: begin
					wm = 1'b1;
					lim = 16'hFFFF;
				end
				4: begin
					wm = 1'($urandom_range(0, 1));
					lim = 16'($urandom_range(65, 600));
				end
				default: begin
					wm = 1'($urandom_range(0, 1));
					lim = 16'($urandom_range(0, 65535));
				end
			endcase
			idle_en <= (ph != 2 && ph != RANDOM_PHASES - 1);
			set_config(wm, lim);
			sent_items = 0;
			rows = 0;
			while (sent_items < RANDOM_ITEMS / RANDOM_PHASES && rows < ROWS_PER_PHASE_MAX) begin
				build_row(wm);
				send_row();
				rows++;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.pending_groups.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+src
src/pbrd_pkg.sv
src/pbrd_ctrl.sv
src/pbrd_datapath.sv
src/packbits_row_decoder.sv
dv/tb_top.sv
